// ===== src/utf8d_pkg.sv =====
// Shared types and constants for the legacy six-byte UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned CP_W   = 31;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0] remaining;
        logic [CP_W-1:0]  partial;
        logic [CNT_W-1:0] consumed;
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic [CNT_W-1:0] bytes_used;
    } t_result;

    localparam t_state STATE_IDLE = '{remaining: '0, partial: '0, consumed: '0};

endpackage

// ===== src/utf8_stream_decoder_core.sv =====
// Top level of the legacy UTF-8 stream decoder: input register, decode step, result register.
//
// Input channel: one raw byte per transaction on i_in_byte (i_in_valid / o_in_ready).
// A zero byte marks end of string.
// Output channel: o_code_point, o_status, o_bytes_used (o_out_valid / i_out_ready).
// Status 0 is a complete character, 1 end of string, 2 an invalid sequence;
// code point is zero unless status is 0.
// A byte accepted into the input register is decoded into the result register as soon
// as that register is empty or its result is being taken.
// Throughput is one byte per cycle while the receiver does not stall: the decode step
// is a single pass of shift, mask and counter logic between the input register and
// the result register.
// Bytes inside a multi-byte sequence produce no result transaction.
// Reset clears both registers' valid flags and the decoder state (awaiting a lead byte).
// When the receiver stalls, the result register holds; the input register fills and
// o_in_ready then drops until the result is taken.
module utf8_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_code_point,
    output logic [1:0]  o_status,
    output logic [2:0]  o_bytes_used
);
    import utf8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_code_point;
    t_status           r_status;
    logic [CNT_W-1:0]  r_bytes_used;
    logic              consume;

    assign consume    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || consume;

    utf8d_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_IDLE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (consume) begin
                r_state     <= n_state;
                r_out_valid <= n_result.valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (consume && n_result.valid) begin
            r_code_point <= n_result.code_point;
            r_status     <= n_result.status;
            r_bytes_used <= n_result.bytes_used;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_status     = r_status;
    assign o_bytes_used = r_bytes_used;

    a_state_cleared_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && n_result.valid |=> r_state.remaining == '0 && r_state.consumed == '0
                                      && r_state.partial == '0)
        else $error("decoder state not cleared after a result");

    a_remaining_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.remaining <= CNT_W'(5))
        else $error("continuation count out of range");

    a_code_point_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_code_point == '0)
        else $error("code point nonzero on non-character result");

    a_zero_count_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bytes_used == '0 |-> o_status == ST_END)
        else $error("zero bytes used on a non-end result");

endmodule

// ===== src/utf8d_step.sv =====
// Per-byte decode step: next decoder state and optional result for one byte.
module utf8d_step (
    input  utf8d_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    output utf8d_pkg::t_state  o_state,
    output utf8d_pkg::t_result o_result
);
    import utf8d_pkg::*;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] rem_dec;
    logic [CP_W-1:0]  shifted;

    assign cnt_inc = i_state.consumed + CNT_W'(1);
    assign rem_dec = i_state.remaining - CNT_W'(1);
    assign shifted = {i_state.partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_state             = i_state;
        o_result.valid      = 1'b0;
        o_result.code_point = '0;
        o_result.status     = ST_DONE;
        o_result.bytes_used = '0;
        if (i_state.remaining == '0) begin
            unique case (i_byte) inside
                8'h00: begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_END;
                end
                [8'h01:8'h7F]: begin
                    o_result.valid      = 1'b1;
                    o_result.code_point = CP_W'(i_byte[6:0]);
                    o_result.bytes_used = CNT_W'(1);
                end
                8'b1111110?: o_state = '{CNT_W'(5), CP_W'(i_byte[0]),   CNT_W'(1)};
                8'b111110??: o_state = '{CNT_W'(4), CP_W'(i_byte[1:0]), CNT_W'(1)};
                8'b11110???: o_state = '{CNT_W'(3), CP_W'(i_byte[2:0]), CNT_W'(1)};
                8'b1110????: o_state = '{CNT_W'(2), CP_W'(i_byte[3:0]), CNT_W'(1)};
                8'b110?????: o_state = '{CNT_W'(1), CP_W'(i_byte[4:0]), CNT_W'(1)};
                default: begin
                    o_result.valid      = 1'b1;
                    o_result.status     = ST_BAD;
                    o_result.bytes_used = CNT_W'(1);
                end
            endcase
        end else if (i_byte == 8'h00) begin
            o_result.valid      = 1'b1;
            o_result.status     = ST_END;
            o_result.bytes_used = i_state.consumed;
        end else if (i_byte[7:6] != 2'b10) begin
            o_result.valid      = 1'b1;
            o_result.status     = ST_BAD;
            o_result.bytes_used = cnt_inc;
        end else if (rem_dec == '0) begin
            o_result.valid      = 1'b1;
            o_result.code_point = shifted;
            o_result.bytes_used = cnt_inc;
        end else begin
            o_state = '{rem_dec, shifted, cnt_inc};
        end
        if (o_result.valid) begin
            o_state = STATE_IDLE;
        end
    end

endmodule
